/* rtl/qped_pkg.sv */
// Shared types, character codes and sizes for the query parameter extract and decode block.
package qped_pkg;

	localparam int unsigned MAX_KEY_CHARS = 8;
	localparam int unsigned KEY_W         = 8 * MAX_KEY_CHARS;
	localparam int unsigned MAX_RES       = 3;
	localparam int unsigned FIFO_DEPTH    = 4;
	localparam int unsigned FIFO_PTR_W    = $clog2(FIFO_DEPTH);
	localparam int unsigned CFG_IDX_W     = 2;
	localparam int unsigned CFG_DATA_W    = KEY_W;

	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CHARS  = 2'd2;

	localparam logic [3:0] KEY_LEN_RESET   = 4'd0;
	localparam logic [7:0] MAX_CHARS_RESET = 8'd127;

	typedef enum logic [1:0] {
		PH_MATCH,
		PH_SKIP,
		PH_VALUE,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		ESC_NONE,
		ESC_PCT,
		ESC_HELD
	} esc_t;

	typedef struct packed {
		logic [7:0] query_byte;
		logic       byte_present;
		logic       end_of_query;
	} query_t;

	typedef struct packed {
		logic [7:0] value_byte;
		logic       is_data;
		logic       found;
		logic       done_res;
	} result_t;

	// all result beats caused by one input beat, oldest in slot 0
	typedef struct packed {
		logic [1:0]                 count;
		result_t [MAX_RES-1:0]      slot;
	} bundle_t;

endpackage

/* rtl/qped_front.sv */
// Front end: configuration registers, per-byte parse state and result bundle builder.
module qped_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  qped_pkg::query_t                    query,
	input  logic                                accept,
	input  logic                                cfg_we,
	input  logic [qped_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [qped_pkg::CFG_DATA_W-1:0]     cfg_data,
	output qped_pkg::bundle_t                   bundle,
	output logic                                bundle_push
);

	typedef struct packed {
		qped_pkg::bundle_t b;
		qped_pkg::phase_t  ph;
		logic [7:0]        cnt;
		qped_pkg::esc_t    st;
	} ctx_t;

	logic [qped_pkg::KEY_W-1:0] key_q;
	logic [3:0]                 key_len_q;
	logic [7:0]                 max_chars_q;

	qped_pkg::phase_t phase_q;
	logic [3:0]       kpos_q;
	logic [7:0]       cnt_q;
	qped_pkg::esc_t   st_q;
	logic [7:0]       held_q;
	logic             kf_q;

	ctx_t             x;
	logic [3:0]       kpos_d;
	logic [7:0]       held_d;
	logic             kf_d;
	logic [3:0]       klen;
	logic [7:0]       key_char;
	qped_pkg::esc_t   st_old;
	logic [7:0]       hex_hi;
	logic [7:0]       hex_lo;

	function automatic logic [7:0] hex_digit(input logic [7:0] c);
		if (c >= qped_pkg::CH_LA)
			return c - qped_pkg::CH_LA + 8'd10;
		else if (c >= qped_pkg::CH_UA)
			return c - qped_pkg::CH_UA + 8'd10;
		return c - qped_pkg::CH_ZERO;
	endfunction

	function automatic ctx_t f_put(input ctx_t xi, input logic [7:0] v, input logic data,
			input logic fnd);
		ctx_t xo;
		xo = xi;
		if (xo.b.count < 2'(qped_pkg::MAX_RES)) begin
			xo.b.slot[xo.b.count] = '{value_byte: v, is_data: data, found: fnd,
				done_res: !data};
			xo.b.count = xo.b.count + 2'd1;
		end
		return xo;
	endfunction

	function automatic ctx_t f_finish(input ctx_t xi);
		ctx_t xo;
		xo = f_put(xi, 8'd0, 1'b0, 1'b1);
		xo.ph = qped_pkg::PH_DONE;
		xo.st = qped_pkg::ESC_NONE;
		return xo;
	endfunction

	function automatic ctx_t f_emit(input ctx_t xi, input logic [7:0] v, input logic [7:0] maxc);
		ctx_t xo;
		xo = f_put(xi, v, 1'b1, 1'b0);
		xo.cnt = xo.cnt + 8'd1;
		if (xo.cnt >= maxc)
			xo = f_finish(xo);
		return xo;
	endfunction

	function automatic ctx_t f_plain(input ctx_t xi, input logic [7:0] c, input logic last,
			input logic [7:0] maxc);
		ctx_t xo;
		xo = xi;
		if (c == qped_pkg::CH_AMP)
			xo = f_finish(xo);
		else if (c == qped_pkg::CH_PLUS)
			xo = f_emit(xo, qped_pkg::CH_SPACE, maxc);
		else if (c == qped_pkg::CH_PCT) begin
			if (last)
				xo = f_emit(xo, c, maxc);
			else
				xo.st = qped_pkg::ESC_PCT;
		end else
			xo = f_emit(xo, c, maxc);
		return xo;
	endfunction

	assign klen     = (key_len_q > 4'(qped_pkg::MAX_KEY_CHARS)) ?
		4'(qped_pkg::MAX_KEY_CHARS) : key_len_q;
	assign key_char = key_q[{kpos_q[2:0], 3'b000} +: 8];
	assign hex_hi   = hex_digit(held_q);
	assign hex_lo   = hex_digit(query.query_byte);

	always_comb begin
		x      = '{b: '0, ph: phase_q, cnt: cnt_q, st: st_q};
		kpos_d = kpos_q;
		held_d = held_q;
		kf_d   = kf_q;
		st_old = qped_pkg::ESC_NONE;
		if (query.byte_present) begin
			unique case (x.ph)
				qped_pkg::PH_MATCH: begin
					if (kpos_q < klen) begin
						if (query.query_byte == qped_pkg::CH_AMP)
							kpos_d = 4'd0;
						else if (query.query_byte == key_char)
							kpos_d = kpos_q + 4'd1;
						else
							x.ph = qped_pkg::PH_SKIP;
					end else if (query.query_byte == qped_pkg::CH_EQ) begin
						x.ph  = qped_pkg::PH_VALUE;
						kf_d  = 1'b1;
						x.cnt = 8'd0;
						x.st  = qped_pkg::ESC_NONE;
						if (max_chars_q == 8'd0)
							x = f_finish(x);
					end else if (query.query_byte == qped_pkg::CH_AMP)
						kpos_d = 4'd0;
					else
						x.ph = qped_pkg::PH_SKIP;
				end
				qped_pkg::PH_SKIP: begin
					if (query.query_byte == qped_pkg::CH_AMP) begin
						x.ph   = qped_pkg::PH_MATCH;
						kpos_d = 4'd0;
					end
				end
				qped_pkg::PH_VALUE: begin
					if (x.st == qped_pkg::ESC_PCT) begin
						held_d = query.query_byte;
						x.st   = qped_pkg::ESC_HELD;
					end else if (x.st == qped_pkg::ESC_HELD) begin
						x.st = qped_pkg::ESC_NONE;
						x = f_emit(x, {hex_hi[3:0], 4'b0000} | hex_lo, max_chars_q);
					end else
						x = f_plain(x, query.query_byte, query.end_of_query, max_chars_q);
				end
				qped_pkg::PH_DONE: begin
				end
				default: begin
				end
			endcase
		end
		if (query.end_of_query) begin
			if (x.ph == qped_pkg::PH_VALUE) begin
				st_old = x.st;
				x.st   = qped_pkg::ESC_NONE;
				if (st_old != qped_pkg::ESC_NONE)
					x = f_emit(x, qped_pkg::CH_PCT, max_chars_q);
				if (st_old == qped_pkg::ESC_HELD && x.ph == qped_pkg::PH_VALUE)
					x = f_plain(x, held_d, 1'b1, max_chars_q);
				if (x.ph == qped_pkg::PH_VALUE)
					x = f_finish(x);
			end else if (x.ph != qped_pkg::PH_DONE)
				x = f_put(x, 8'd0, 1'b0, kf_d);
			x.ph   = qped_pkg::PH_MATCH;
			x.cnt  = 8'd0;
			x.st   = qped_pkg::ESC_NONE;
			kpos_d = 4'd0;
			held_d = 8'd0;
			kf_d   = 1'b0;
		end
	end

	assign bundle      = x.b;
	assign bundle_push = accept && (x.b.count != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q       <= '0;
			key_len_q   <= qped_pkg::KEY_LEN_RESET;
			max_chars_q <= qped_pkg::MAX_CHARS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				qped_pkg::REG_KEY_BYTES:  key_q       <= cfg_data;
				qped_pkg::REG_KEY_LENGTH: key_len_q   <= cfg_data[3:0];
				qped_pkg::REG_MAX_CHARS:  max_chars_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= qped_pkg::PH_MATCH;
			kpos_q  <= 4'd0;
			cnt_q   <= 8'd0;
			st_q    <= qped_pkg::ESC_NONE;
			held_q  <= 8'd0;
			kf_q    <= 1'b0;
		end else if (accept) begin
			phase_q <= x.ph;
			kpos_q  <= kpos_d;
			cnt_q   <= x.cnt;
			st_q    <= x.st;
			held_q  <= held_d;
			kf_q    <= kf_d;
		end
	end

endmodule

/* rtl/qped_fifo.sv */
// Small bundle queue between the front end and the result sequencer.
module qped_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  qped_pkg::bundle_t wr_data,
	output logic              full,
	input  logic              rd_en,
	output qped_pkg::bundle_t rd_data,
	output logic              empty
);

	qped_pkg::bundle_t                 mem_q [qped_pkg::FIFO_DEPTH];
	logic [qped_pkg::FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [qped_pkg::FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [qped_pkg::FIFO_PTR_W:0]     count_q;
	logic                              do_wr;
	logic                              do_rd;

	assign full    = (count_q == (qped_pkg::FIFO_PTR_W+1)'(qped_pkg::FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/qped_back.sv */
// Back end: holds one bundle and hands out its result beats one per pop.
module qped_back (
	input  logic              clk,
	input  logic              arst_n,
	input  qped_pkg::bundle_t fifo_data,
	input  logic              fifo_empty,
	output logic              fifo_rd,
	output qped_pkg::result_t result,
	output logic              empty,
	input  logic              pop
);

	qped_pkg::bundle_t cur_q;
	logic [1:0]        idx_q;
	logic              have_q;
	logic              beat;
	logic              last_beat;

	assign beat      = pop && have_q;
	assign last_beat = beat && (idx_q == cur_q.count - 2'd1);
	assign fifo_rd   = !fifo_empty && (!have_q || last_beat);
	assign empty     = !have_q;
	assign result    = cur_q.slot[idx_q];

	always_ff @(posedge clk) begin
		if (fifo_rd)
			cur_q <= fifo_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (fifo_rd) begin
			have_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (last_beat) begin
			have_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (beat)
			idx_q <= idx_q + 2'd1;
	end

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		have_q |-> cur_q.count != 2'd0)
		else $error("held bundle has no results");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		have_q |-> idx_q < cur_q.count)
		else $error("beat index past bundle end");

	a_close_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		have_q && result.done_res |-> idx_q == cur_q.count - 2'd1)
		else $error("closing beat not last in bundle");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		have_q && !pop |=> have_q && idx_q == $past(idx_q))
		else $error("beat index moved while stalled");

endmodule

/* rtl/query_param_extract_decode.sv */
// Top level: query parameter extractor with URL percent decoding.
//
// Input channel (push/full/query): one query byte per beat, or an empty beat
// that only carries end_of_query. A beat is taken when push is high and full
// is low; the front end parses it in that cycle, so one beat per cycle is
// sustained while the result queue has room.
// Result channel (empty/pop/result): data beats carry decoded value bytes;
// the closing beat (is_data low, done_res high) carries found. Each input
// beat yields zero to three result beats, delivered one per cycle while pop
// is high. A result passes through the bundle queue and the result stage.
// Between the parser and the result stage sits a four-bundle queue: when the
// receiver holds pop low, input keeps flowing until that queue fills, then
// full rises. Output throughput is one beat per cycle while pop is high.
// Configuration (cfg_we/cfg_index/cfg_data): key bytes, key length and the
// value length limit; the user must write them only while the block is idle,
// which the block does not enforce. Reset clears parse state, queue and result
// stage; key length resets to 0 and the value limit to 127.
module query_param_extract_decode (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  qped_pkg::query_t                 query,
	output logic                             empty,
	input  logic                             pop,
	output qped_pkg::result_t                result,
	input  logic                             cfg_we,
	input  logic [qped_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [qped_pkg::CFG_DATA_W-1:0]  cfg_data
);

	qped_pkg::bundle_t bundle;
	qped_pkg::bundle_t fifo_data;
	logic              bundle_push;
	logic              fifo_empty;
	logic              fifo_rd;
	logic              accept;

	assign accept = push && !full;

	qped_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.query       (query),
		.accept      (accept),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.bundle      (bundle),
		.bundle_push (bundle_push)
	);

	qped_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (bundle_push),
		.wr_data (bundle),
		.full    (full),
		.rd_en   (fifo_rd),
		.rd_data (fifo_data),
		.empty   (fifo_empty)
	);

	qped_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_data  (fifo_data),
		.fifo_empty (fifo_empty),
		.fifo_rd    (fifo_rd),
		.result     (result),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for query_param_extract_decode: directed table, then random queries.
`timescale 1ns / 100ps

module tb_top;
	import qped_pkg::*;

	typedef struct {
		bit                  is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [63:0]         data;
		query_t              q;
		int                  typed_n;
		result_t             typed [3];
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	query_t                query;
	logic                  empty;
	logic                  pop;
	result_t               result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// register shadow
	logic [63:0] cfg_key     = '0;
	logic [3:0]  cfg_key_len = KEY_LEN_RESET;
	logic [7:0]  cfg_max     = MAX_CHARS_RESET;

	// parser shadow
	phase_t      pv_phase   = PH_MATCH;
	esc_t        pv_esc     = ESC_NONE;
	logic [3:0]  pv_key_pos = '0;
	logic [7:0]  pv_emitted = '0;
	logic [7:0]  pv_held    = '0;
	logic        pv_key_hit = 1'b0;

	result_t     step_out [$];
	result_t     decoded_due [$];
	stim_row_t   directed_rows [$];
	int          fail_count = 0;
	int          beats_sent = 0;
	int          stall_left = 0;
	bit          idle_en    = 1'b1;

	query_param_extract_decode dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.query    (query),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("query_param_extract_decode verification failed");
		$finish;
	end

	function automatic result_t data_res(input logic [7:0] v);
		result_t r;
		r.value_byte = v;
		r.is_data    = 1'b1;
		r.found      = 1'b0;
		r.done_res   = 1'b0;
		return r;
	endfunction

	function automatic result_t close_res(input logic f);
		result_t r;
		r.value_byte = 8'h00;
		r.is_data    = 1'b0;
		r.found      = f;
		r.done_res   = 1'b1;
		return r;
	endfunction

	function automatic logic [7:0] nibble_of(input logic [7:0] c);
		if (c >= CH_LA)
			return c - CH_LA + 8'd10;
		if (c >= CH_UA)
			return c - CH_UA + 8'd10;
		return c - CH_ZERO;
	endfunction

	task automatic put_result(input result_t r);
		if (step_out.size() < MAX_RES)
			step_out.push_back(r);
	endtask

	task automatic close_value();
		put_result(close_res(1'b1));
		pv_phase = PH_DONE;
		pv_esc   = ESC_NONE;
	endtask

	task automatic emit_byte(input logic [7:0] v);
		put_result(data_res(v));
		pv_emitted = pv_emitted + 8'd1;
		if (pv_emitted >= cfg_max)
			close_value();
	endtask

	task automatic plain_byte(input logic [7:0] c, input logic last);
		if (c == CH_AMP)
			close_value();
		else if (c == CH_PLUS)
			emit_byte(CH_SPACE);
		else if (c == CH_PCT) begin
			if (last)
				emit_byte(c);
			else
				pv_esc = ESC_PCT;
		end else
			emit_byte(c);
	endtask

	// results caused by one accepted beat land in step_out
	task automatic decode_beat(input query_t q);
		logic [7:0] c;
		logic [7:0] kc;
		logic [7:0] hi;
		logic [7:0] lo;
		logic [3:0] klen;
		logic       last;
		esc_t       stage;
		c    = q.query_byte;
		last = q.end_of_query;
		klen = (cfg_key_len > 4'(MAX_KEY_CHARS)) ? 4'(MAX_KEY_CHARS) : cfg_key_len;
		if (q.byte_present) begin
			case (pv_phase)
			PH_MATCH: begin
				if (pv_key_pos < klen) begin
					kc = cfg_key[8*pv_key_pos[2:0] +: 8];
					if (c == CH_AMP)
						pv_key_pos = '0;
					else if (c == kc)
						pv_key_pos = pv_key_pos + 4'd1;
					else
						pv_phase = PH_SKIP;
				end else if (c == CH_EQ) begin
					pv_phase   = PH_VALUE;
					pv_key_hit = 1'b1;
					pv_emitted = '0;
					pv_esc     = ESC_NONE;
					if (cfg_max == 8'd0)
						close_value();
				end else if (c == CH_AMP)
					pv_key_pos = '0;
				else
					pv_phase = PH_SKIP;
			end
			PH_SKIP: begin
				if (c == CH_AMP) begin
					pv_phase   = PH_MATCH;
					pv_key_pos = '0;
				end
			end
			PH_VALUE: begin
				if (pv_esc == ESC_PCT) begin
					pv_held = c;
					pv_esc  = ESC_HELD;
				end else if (pv_esc == ESC_HELD) begin
					hi     = nibble_of(pv_held);
					lo     = nibble_of(c);
					pv_esc = ESC_NONE;
					emit_byte({hi[3:0], 4'h0} | lo);
				end else
					plain_byte(c, last);
			end
			default: ;
			endcase
		end
		if (last) begin
			if (pv_phase == PH_VALUE) begin
				stage  = pv_esc;
				pv_esc = ESC_NONE;
				if (stage != ESC_NONE)
					emit_byte(CH_PCT);
				if (stage == ESC_HELD && pv_phase == PH_VALUE)
					plain_byte(pv_held, 1'b1);
				if (pv_phase == PH_VALUE)
					close_value();
			end else if (pv_phase != PH_DONE)
				put_result(close_res(pv_key_hit));
			pv_phase   = PH_MATCH;
			pv_key_pos = '0;
			pv_emitted = '0;
			pv_esc     = ESC_NONE;
			pv_held    = '0;
			pv_key_hit = 1'b0;
		end
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s expected %0h got %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && !empty && pop) begin
			if (decoded_due.size() == 0) begin
				$error("unexpected result beat %0h", result);
				fail_count++;
			end else begin
				want = decoded_due.pop_front();
				check_field("value_byte", want.value_byte, result.value_byte);
				check_field("is_data", want.is_data, result.is_data);
				check_field("found", want.found, result.found);
				check_field("done_res", want.done_res, result.done_res);
			end
		end
	end

	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				pop = 1'b0;
				stall_left--;
			end else if (idle_en && $urandom_range(0, 9) == 0) begin
				pop        = 1'b0;
				stall_left = $urandom_range(1, 17) - 1;
			end else
				pop = 1'b1;
		end
	end

	// all driving tasks start and end at a falling edge
	task automatic push_beat(input stim_row_t r);
		if (idle_en && $urandom_range(0, 7) == 0) begin
			push = 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		push  = 1'b1;
		query = r.q;
		@(posedge clk);
		while (full)
			@(posedge clk);
		step_out.delete();
		decode_beat(r.q);
		if (r.typed_n < 0) begin
			foreach (step_out[i])
				decoded_due.push_back(step_out[i]);
		end else begin
			for (int i = 0; i < r.typed_n; i++)
				decoded_due.push_back(r.typed[i]);
		end
		if (r.q.byte_present || r.q.end_of_query)
			beats_sent++;
		@(negedge clk);
		push = 1'b0;
	endtask

	task automatic wait_drained();
		while (decoded_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		case (idx)
		REG_KEY_BYTES:  cfg_key     = val;
		REG_KEY_LENGTH: cfg_key_len = val[3:0];
		REG_MAX_CHARS:  cfg_max     = val[7:0];
		default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic add_beat(input logic [7:0] b, input bit p, input bit e, input int n = -1,
			input result_t r0 = '0, input result_t r1 = '0, input result_t r2 = '0);
		stim_row_t r;
		r.is_cfg           = 1'b0;
		r.idx              = '0;
		r.data             = '0;
		r.q.query_byte     = b;
		r.q.byte_present   = p;
		r.q.end_of_query   = e;
		r.typed_n          = n;
		r.typed[0]         = r0;
		r.typed[1]         = r1;
		r.typed[2]         = r2;
		directed_rows.push_back(r);
	endtask

	task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		stim_row_t r;
		r.is_cfg  = 1'b1;
		r.idx     = idx;
		r.data    = val;
		r.q       = '0;
		r.typed_n = 0;
		directed_rows.push_back(r);
	endtask

	function automatic logic [7:0] value_char();
		string hexset;
		int    pick;
		hexset = "0123456789abcdefABCDEF";
		pick   = $urandom_range(0, 9);
		if (pick < 3)
			return hexset[$urandom_range(0, 21)];
		if (pick == 3)
			return CH_PLUS;
		if (pick == 4)
			return CH_PCT;
		if (pick == 5 && $urandom_range(0, 3) == 0)
			return CH_AMP;
		return 8'($urandom_range(1, 255));
	endfunction

	task automatic send_random_query();
		logic [7:0] text [$];
		stim_row_t  r;
		int         klen;
		int         cut;
		int         kind;
		bit         end_on_byte;
		klen = (cfg_key_len > 4'(MAX_KEY_CHARS)) ? MAX_KEY_CHARS : cfg_key_len;
		for (int f = 0; f < $urandom_range(1, 3); f++) begin
			if (f > 0)
				text.push_back(CH_AMP);
			kind = $urandom_range(0, 9);
			if (kind < 8) begin
				cut = (kind < 6) ? klen : $urandom_range(0, klen);
				for (int i = 0; i < cut; i++)
					text.push_back(cfg_key[8*i +: 8]);
				if (kind >= 6)
					text.push_back(8'($urandom_range(1, 255)));
				text.push_back(CH_EQ);
				for (int i = $urandom_range(0, 4); i > 0; i--) begin
					text.push_back(value_char());
					if (text[$] == CH_PCT && $urandom_range(0, 2) != 0) begin
						text.push_back(value_char());
						text.push_back(value_char());
					end
				end
			end else begin
				for (int i = $urandom_range(0, 5); i > 0; i--)
					text.push_back(8'($urandom_range(1, 255)));
			end
		end
		end_on_byte = (text.size() != 0) && ($urandom_range(0, 2) != 0);
		r.is_cfg  = 1'b0;
		r.idx     = '0;
		r.data    = '0;
		r.typed_n = -1;
		foreach (text[i]) begin
			if ($urandom_range(0, 19) == 0) begin
				r.q.query_byte   = 8'($urandom_range(1, 255));
				r.q.byte_present = 1'b0;
				r.q.end_of_query = 1'b0;
				push_beat(r);
			end
			r.q.query_byte   = text[i];
			r.q.byte_present = 1'b1;
			r.q.end_of_query = end_on_byte && (i == text.size() - 1);
			push_beat(r);
		end
		if (!end_on_byte) begin
			r.q.query_byte   = 8'($urandom_range(1, 255));
			r.q.byte_present = 1'b0;
			r.q.end_of_query = 1'b1;
			push_beat(r);
		end
	endtask

	initial begin
		logic [7:0]  max_set [5];
		logic [3:0]  len_set [5];
		logic [63:0] key_val;
		int          target;
		arst_n    = 1'b0;
		push      = 1'b0;
		query     = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// after reset: empty key, limit 127
		add_beat(CH_EQ, 1, 0, 0);
		add_beat("x", 1, 1, 2, data_res("x"), close_res(1'b1));
		add_beat(8'h01, 0, 1, 1, close_res(1'b0));
		add_beat(8'hFF, 0, 0, 0);
		add_cfg(REG_KEY_BYTES, 64'h6261);
		add_cfg(REG_KEY_LENGTH, 64'd2);
		add_beat("a", 1, 0);
		add_beat("b", 1, 0);
		add_beat(CH_EQ, 1, 0);
		add_beat(CH_PLUS, 1, 0, 1, data_res(CH_SPACE));
		add_beat(CH_PCT, 1, 0);
		add_beat("4", 1, 0);
		add_beat("1", 1, 0);
		add_beat(CH_PCT, 1, 0);
		add_beat("f", 1, 0);
		add_beat("F", 1, 0);
		add_beat(8'hFF, 1, 0, 1, data_res(8'hFF));
		add_beat(CH_PCT, 1, 0);
		add_beat("z", 1, 0);
		add_beat(8'h5A, 0, 1);
		// key holds an ampersand, length above the maximum
		add_cfg(REG_KEY_BYTES, 64'h2661);
		add_cfg(REG_KEY_LENGTH, 64'd15);
		add_beat("a", 1, 0);
		add_beat(CH_AMP, 1, 0);
		add_beat(8'h01, 0, 1, 1, close_res(1'b0));
		// zero limit closes on the equals sign
		add_cfg(REG_KEY_LENGTH, 64'd1);
		add_cfg(REG_MAX_CHARS, 64'd0);
		add_beat("a", 1, 0);
		add_beat(CH_EQ, 1, 0, 1, close_res(1'b1));
		add_beat("q", 1, 1, 0);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				wait_drained();
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			end else
				push_beat(directed_rows[i]);
		end

		max_set = '{8'd1, 8'd255, 8'd0, 8'd3, 8'($urandom_range(2, 9))};
		len_set = '{4'd3, 4'd8, 4'd0, 4'd15, 4'($urandom_range(1, 7))};
		for (int p = 0; p < 5; p++) begin
			wait_drained();
			key_val = (p == 1) ? '1 : {$urandom, $urandom};
			write_reg(REG_KEY_BYTES, key_val);
			write_reg(REG_KEY_LENGTH, 64'(len_set[p]));
			write_reg(REG_MAX_CHARS, 64'(max_set[p]));
			idle_en = (p != 4);
			target  = beats_sent + 10;
			while (beats_sent < target)
				send_random_query();
		end

		wait_drained();
		if (fail_count == 0)
			$display("query_param_extract_decode verification clean");
		else
			$display("query_param_extract_decode verification failed");
		$finish;
	end

endmodule

/* query_param_extract_decode.f */
rtl/qped_pkg.sv
rtl/qped_front.sv
rtl/qped_fifo.sv
rtl/qped_back.sv
rtl/query_param_extract_decode.sv
sim/tb_top.sv
